[hdl/fpmv_pkg.sv]
// ----------------------------------------------------------------------------
// fpmv_pkg
// Shared types and constants for the Q12 3x3 matrix by vector multiplier.
// ----------------------------------------------------------------------------
package fpmv_pkg;

    // operand and result widths
    localparam int unsigned COEF_W = 16;
    localparam int unsigned VEC_W  = 16;
    localparam int unsigned PROD_W = COEF_W + VEC_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned Q_FRAC = 12;
    localparam int unsigned MAC_W  = 21;
    localparam int unsigned IR_W   = 16;

    // configuration port geometry
    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 5;

    // saturation limits in mac width
    localparam logic signed [MAC_W-1:0] IR_MAX = 21'sd32767;
    localparam logic signed [MAC_W-1:0] IR_MIN = -21'sd32768;

    // register word indexes
    localparam logic [2:0] REG_M11_M12 = 3'd0;
    localparam logic [2:0] REG_M13_M21 = 3'd1;
    localparam logic [2:0] REG_M22_M23 = 3'd2;
    localparam logic [2:0] REG_M31_M32 = 3'd3;
    localparam logic [2:0] REG_M33     = 3'd4;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [VEC_W-1:0]  t_comp;
    typedef logic signed [MAC_W-1:0]  t_mac;
    typedef logic signed [IR_W-1:0]   t_ir;

    // one matrix row, element 1 in the low slot
    typedef struct packed {
        t_coef c3;
        t_coef c2;
        t_coef c1;
    } t_row;

    // whole configured matrix
    typedef struct packed {
        t_row r3;
        t_row r2;
        t_row r1;
    } t_matrix;

    // one input vector
    typedef struct packed {
        t_comp z;
        t_comp y;
        t_comp x;
    } t_vec;

endpackage

[hdl/fpmv_cfg.sv]
// ----------------------------------------------------------------------------
// fpmv_cfg
// APB register file holding the nine Q12 matrix coefficients.
// ----------------------------------------------------------------------------
module fpmv_cfg
    import fpmv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_matrix           o_matrix
);

    logic [31:0] r_m11_m12;
    logic [31:0] r_m13_m21;
    logic [31:0] r_m22_m23;
    logic [31:0] r_m31_m32;
    logic [15:0] r_m33;
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    // register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m11_m12 <= '0;
            r_m13_m21 <= '0;
            r_m22_m23 <= '0;
            r_m31_m32 <= '0;
            r_m33     <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_M11_M12: r_m11_m12 <= pwdata;
                REG_M13_M21: r_m13_m21 <= pwdata;
                REG_M22_M23: r_m22_m23 <= pwdata;
                REG_M31_M32: r_m31_m32 <= pwdata;
                REG_M33:     r_m33     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_M11_M12: prdata = r_m11_m12;
            REG_M13_M21: prdata = r_m13_m21;
            REG_M22_M23: prdata = r_m22_m23;
            REG_M31_M32: prdata = r_m31_m32;
            REG_M33:     prdata = {16'h0000, r_m33};
            default:     prdata = '0;
        endcase
    end

    // unpack the halves into matrix elements
    assign o_matrix.r1.c1 = r_m11_m12[15:0];
    assign o_matrix.r1.c2 = r_m11_m12[31:16];
    assign o_matrix.r1.c3 = r_m13_m21[15:0];
    assign o_matrix.r2.c1 = r_m13_m21[31:16];
    assign o_matrix.r2.c2 = r_m22_m23[15:0];
    assign o_matrix.r2.c3 = r_m22_m23[31:16];
    assign o_matrix.r3.c1 = r_m31_m32[15:0];
    assign o_matrix.r3.c2 = r_m31_m32[31:16];
    assign o_matrix.r3.c3 = r_m33;

endmodule

[hdl/fpmv_row.sv]
// ----------------------------------------------------------------------------
// fpmv_row
// One row dot product: three 16x16 products, sum, Q12 shift and clamp.
// ----------------------------------------------------------------------------
module fpmv_row
    import fpmv_pkg::*;
(
    input  t_row  i_row,
    input  t_vec  i_vec,
    output t_mac  o_mac,
    output t_ir   o_ir
);

    logic signed [PROD_W-1:0] prod1;
    logic signed [PROD_W-1:0] prod2;
    logic signed [PROD_W-1:0] prod3;
    logic signed [SUM_W-1:0]  sum;

    // signed products
    assign prod1 = PROD_W'(i_row.c1) * PROD_W'(i_vec.x);
    assign prod2 = PROD_W'(i_row.c2) * PROD_W'(i_vec.y);
    assign prod3 = PROD_W'(i_row.c3) * PROD_W'(i_vec.z);

    // exact sum, the range never reaches the 34-bit wrap
    assign sum = SUM_W'(prod1) + SUM_W'(prod2) + SUM_W'(prod3);

    // arithmetic shift by the fraction bits, floor rounding
    assign o_mac = sum[Q_FRAC+MAC_W-1:Q_FRAC];

    // clamp to signed 16
    always_comb begin
        if (o_mac > IR_MAX) begin
            o_ir = IR_MAX[IR_W-1:0];
        end else if (o_mac < IR_MIN) begin
            o_ir = IR_MIN[IR_W-1:0];
        end else begin
            o_ir = o_mac[IR_W-1:0];
        end
    end

endmodule

[hdl/fixed_point_matrix_vector_multiply_top.sv]
// Q12 3x3 matrix by vector multiplier. Load the nine signed 16-bit matrix
// coefficients over the APB port while the block is idle, then stream signed
// 16-bit vectors in; each vector yields one result transaction with the three
// row dot products shifted right by 12 (21-bit mac values) and the same values
// clamped to signed 16 bits. The block takes one transaction per clock unless
// the result side stalls; an accepted vector is held in an input register that
// feeds three parallel row units whose outputs land in a result register, and
// the two registers are pipelined so input is accepted while a result waits.
// ----------------------------------------------------------------------------
// fixed_point_matrix_vector_multiply_top
// Top level: configuration registers, input register, row units, result
// register with valid/ready flow control.
// ----------------------------------------------------------------------------
module fixed_point_matrix_vector_multiply_top
    import fpmv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // vector input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_comp             i_vec_x,
    input  t_comp             i_vec_y,
    input  t_comp             i_vec_z,
    // results
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_mac              o_mac_x,
    output t_mac              o_mac_y,
    output t_mac              o_mac_z,
    output t_ir               o_ir_x,
    output t_ir               o_ir_y,
    output t_ir               o_ir_z
);

    t_matrix matrix;
    logic    r_in_valid;
    logic    n_in_valid;
    t_vec    r_vec;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    out_free;
    logic    in_take;
    logic    out_load;
    t_mac    mac_x;
    t_mac    mac_y;
    t_mac    mac_z;
    t_ir     ir_x;
    t_ir     ir_y;
    t_ir     ir_z;
    t_mac    r_mac_x;
    t_mac    r_mac_y;
    t_mac    r_mac_z;
    t_ir     r_ir_x;
    t_ir     r_ir_y;
    t_ir     r_ir_z;

    // coefficient registers
    fpmv_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_matrix (matrix)
    );

    // flow control between the two register stages
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid  = in_take || (r_in_valid && !out_free);
        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_vec.x <= i_vec_x;
            r_vec.y <= i_vec_y;
            r_vec.z <= i_vec_z;
        end
    end

    // one unit per matrix row
    fpmv_row u_row_x (.i_row(matrix.r1), .i_vec(r_vec), .o_mac(mac_x), .o_ir(ir_x));
    fpmv_row u_row_y (.i_row(matrix.r2), .i_vec(r_vec), .o_mac(mac_y), .o_ir(ir_y));
    fpmv_row u_row_z (.i_row(matrix.r3), .i_vec(r_vec), .o_mac(mac_z), .o_ir(ir_z));

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_mac_x <= mac_x;
            r_mac_y <= mac_y;
            r_mac_z <= mac_z;
            r_ir_x  <= ir_x;
            r_ir_y  <= ir_y;
            r_ir_z  <= ir_z;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mac_x     = r_mac_x;
    assign o_mac_y     = r_mac_y;
    assign o_mac_z     = r_mac_z;
    assign o_ir_x      = r_ir_x;
    assign o_ir_y      = r_ir_y;
    assign o_ir_z      = r_ir_z;

`ifndef SYNTHESIS
    // input stalls only when both stages hold data and the sink is stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    // an accepted transaction always lands in the input register
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_valid)
        else $error("accepted transaction lost at input register");

    // a loaded input stage with a free output stage produces a result next cycle
    a_out_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("input stage did not advance to result register");

    // clamped value matches mac when mac is in range
    a_ir_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_mac_x <= IR_MAX) && (r_mac_x >= IR_MIN))
            |-> (r_ir_x == r_mac_x[IR_W-1:0]))
        else $error("clamped row one value disagrees with mac");

    // clamped value pinned at the limit when mac is over range
    a_ir_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_mac_y > IR_MAX)) |-> (r_ir_y == IR_MAX[IR_W-1:0]))
        else $error("row two value not saturated high");
`endif

endmodule
